>>> rtl/islc_pkg.sv
// Shared types and constants for the indexed sequence list core.
package islc_pkg;

    // Request codes carried on the slave-side tuser.
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_READ   = 2'd3
    } t_req;

    // Status codes carried on the master-side tuser.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_MISS  = 2'd3
    } t_status;

    // Shift commands broadcast to every cell of the row.
    typedef struct packed {
        logic ins;
        logic rem;
    } t_ctrl;

    // Match bits examined per cycle by the search scanner.
    localparam int CHUNK_LOG = 3;
    localparam int CHUNK     = 1 << CHUNK_LOG;

    // Fixed field widths of the stream payload.
    localparam int POS_BITS   = 7;
    localparam int DATA_BITS  = 32;
    localparam int INDEX_BITS = 6;
    localparam int LEN_BITS   = 7;

endpackage

>>> rtl/islc_cell.sv
// One storage cell of the list row: holds a word, shifts with its neighbors.
module islc_cell #(
    parameter int IDX       = 0,
    parameter int CW        = 7,
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  islc_pkg::t_ctrl      i_ctrl,
    input  logic [CW-1:0]        i_pos,
    input  logic [CW-1:0]        i_count,
    input  logic [WORD_BITS-1:0] i_value,
    input  logic [WORD_BITS-1:0] i_left,
    input  logic [WORD_BITS-1:0] i_right,
    output logic [WORD_BITS-1:0] o_word,
    output logic [WORD_BITS-1:0] o_hit,
    output logic                 o_match
);
    import islc_pkg::*;

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [WORD_BITS-1:0] r_word;

    // Insert: cells past the position take the left neighbor, the position takes the value.
    // Remove: cells from the position on take the right neighbor.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins) begin
            if (MY_IDX > i_pos) begin
                r_word <= i_left;
            end else if (MY_IDX == i_pos) begin
                r_word <= i_value;
            end
        end else if (i_ctrl.rem && (MY_IDX >= i_pos)) begin
            r_word <= i_right;
        end
    end

    assign o_word  = r_word;
    assign o_hit   = (MY_IDX == i_pos) ? r_word : '0;
    assign o_match = (MY_IDX < i_count) && (r_word == i_value);

endmodule

>>> rtl/islc_find.sv
// First-match scanner: walks the registered match vector a chunk per cycle.
module islc_find #(
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic [DEPTH-1:0]           i_match,
    input  logic                       i_stall,
    output logic                       o_done,
    output logic                       o_found,
    output logic [$clog2(DEPTH)-1:0]   o_index
);
    import islc_pkg::*;

    localparam int NCHUNK = (DEPTH + CHUNK - 1) / CHUNK;
    localparam int CHW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int IW     = $clog2(DEPTH);
    localparam int VW     = NCHUNK * CHUNK;

    logic [VW-1:0]            r_match;
    logic [CHW-1:0]           r_chunk;
    logic                     r_busy;
    logic [CHW+CHUNK_LOG-1:0] w_base;
    logic [CHUNK-1:0]         w_bits;
    logic [CHUNK_LOG-1:0]     w_lo;
    logic                     w_last;

    assign w_base = {r_chunk, {CHUNK_LOG{1'b0}}};
    assign w_bits = r_match[w_base +: CHUNK];
    assign w_last = (r_chunk == CHW'(NCHUNK - 1));

    // Lowest set bit of the current chunk.
    always_comb begin
        w_lo = '0;
        for (int k = CHUNK - 1; k >= 0; k--) begin
            if (w_bits[k]) begin
                w_lo = CHUNK_LOG'(k);
            end
        end
    end

    assign o_found = |w_bits;
    assign o_done  = r_busy && (o_found || w_last);
    assign o_index = IW'({r_chunk, w_lo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_chunk <= '0;
        end else if (i_load) begin
            r_busy  <= 1'b1;
            r_chunk <= '0;
        end else if (r_busy) begin
            if (o_done) begin
                if (!i_stall) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_chunk <= CHW'(r_chunk + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_match <= VW'(i_match);
        end
    end

endmodule

>>> rtl/indexed_sequence_list_core.sv
// Top level of the indexed sequence list: request FSM, cell row, search scanner.
//
// Ordered list of up to DEPTH signed words kept in a row of cells, front at
// index zero. One request transaction enters on the slave side (tuser holds
// the request code, tdata the position and the word) and exactly one result
// transaction leaves on the master side (tuser holds the status, tdata the
// returned word, the match index and the length after the request).
// Insert, remove and read act on the cell row in the execute state, where the
// result is registered once the output register is free. A search compares
// all cells at once and loads the match vector into the scanner, which walks
// it eight cells per cycle until the first match or the last chunk; the result
// is registered once the scanner finishes and the output register is free.
// One request is in flight at a time; a request is taken while the previous
// result still waits on the master side, but its result is not written until
// the output register frees up. When the receiver stalls, hold the result and
// the finished request in place; the cell row does not move.
// Reset clears the length to zero, drops any waiting result and returns to
// idle; no request is taken while reset is held. The cell contents are left
// as they are and only read below the length.
module indexed_sequence_list_core #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [6:0] position, [38:7] value, [39] zero
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] data, [37:32] found_index, [44:38] length
    output logic [1:0]  m_tuser    // [1:0] status
);
    import islc_pkg::*;

    localparam int CW = ($clog2(DEPTH + 1) > POS_BITS) ? $clog2(DEPTH + 1) : POS_BITS;
    localparam int IW = $clog2(DEPTH);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } t_state;

    t_state                r_state;
    t_req                  r_req;
    logic [POS_BITS-1:0]   r_pos;
    logic [DATA_BITS-1:0]  r_value;
    logic [CW-1:0]         r_count;
    logic                  r_out_valid;
    t_status               r_status;
    logic [DATA_BITS-1:0]  r_data;
    logic [INDEX_BITS-1:0] r_index;
    logic [LEN_BITS-1:0]   r_length;

    logic [CW-1:0]         w_pos;
    logic [WORD_BITS-1:0]  w_value;
    logic                  w_out_free;
    logic                  w_exec;
    logic                  w_ins_ok;
    logic                  w_rem_ok;
    logic                  w_rd_ok;
    t_ctrl                 w_ctrl;
    logic [WORD_BITS-1:0]  w_word [DEPTH];
    logic [WORD_BITS-1:0]  w_hit  [DEPTH];
    logic [DEPTH-1:0]      w_match;
    logic [WORD_BITS-1:0]  w_pick;
    logic [DATA_BITS-1:0]  w_pick_ext;
    logic                  w_find_load;
    logic                  w_find_done;
    logic                  w_find_found;
    logic [IW-1:0]         w_find_index;
    logic [CW-1:0]         n_count;
    t_status               w_exec_status;
    logic [DATA_BITS-1:0]  w_exec_data;
    logic                  w_out_load;

    assign s_tready   = i_rst_n && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || m_tready;
    assign w_exec     = (r_state == S_EXEC) && w_out_free;

    // Stored words keep the low WORD_BITS bits of the sign-extended value.
    assign w_pos   = CW'(r_pos);
    assign w_value = WORD_BITS'($signed(r_value));

    assign w_ins_ok = (r_req == REQ_INSERT) && (w_pos <= r_count) && (r_count != FULL_COUNT);
    assign w_rem_ok = (r_req == REQ_REMOVE) && (w_pos < r_count);
    assign w_rd_ok  = (r_req == REQ_READ) && (w_pos < r_count);

    assign w_ctrl.ins = w_exec && w_ins_ok;
    assign w_ctrl.rem = w_exec && w_rem_ok;

    // Row of cells; each hands its word to both neighbors every cycle.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        islc_cell #(
            .IDX       (g),
            .CW        (CW),
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_pos   (w_pos),
            .i_count (r_count),
            .i_value (w_value),
            .i_left  ((g == 0) ? w_value : w_word[(g == 0) ? 0 : g - 1]),
            .i_right ((g == DEPTH - 1) ? w_value : w_word[(g == DEPTH - 1) ? g : g + 1]),
            .o_word  (w_word[g]),
            .o_hit   (w_hit[g]),
            .o_match (w_match[g])
        );
    end

    // Only the addressed cell drives a nonzero word, so OR the row together.
    always_comb begin
        w_pick = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_pick = w_pick | w_hit[k];
        end
    end

    assign w_pick_ext = DATA_BITS'($signed(w_pick));

    assign w_find_load = (r_state == S_EXEC) && (r_req == REQ_SEARCH);

    islc_find #(
        .DEPTH (DEPTH)
    ) u_find (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_find_load),
        .i_match (w_match),
        .i_stall (!w_out_free),
        .o_done  (w_find_done),
        .o_found (w_find_found),
        .o_index (w_find_index)
    );

    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins) begin
            n_count = CW'(r_count + 1'b1);
        end else if (w_ctrl.rem) begin
            n_count = CW'(r_count - 1'b1);
        end
    end

    // Status and word of an insert, remove or read, taken before the row moves.
    // The position check of an insert comes before the full check.
    always_comb begin
        w_exec_status = STAT_OK;
        w_exec_data   = '0;
        priority case (r_req)
            REQ_INSERT: begin
                if (w_pos > r_count) begin
                    w_exec_status = STAT_RANGE;
                end else if (r_count == FULL_COUNT) begin
                    w_exec_status = STAT_FULL;
                end
            end
            REQ_REMOVE: begin
                if (w_rem_ok) begin
                    w_exec_data = w_pick_ext;
                end else begin
                    w_exec_status = STAT_RANGE;
                end
            end
            default: begin
                if (w_rd_ok) begin
                    w_exec_data = w_pick_ext;
                end else begin
                    w_exec_status = STAT_RANGE;
                end
            end
        endcase
    end

    // A result is written once the output register is free to take it.
    assign w_out_load = w_out_free &&
                        (((r_state == S_EXEC) && (r_req != REQ_SEARCH)) ||
                         ((r_state == S_SCAN) && w_find_done));

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_req   <= t_req'(s_tuser);
            r_pos   <= s_tdata[POS_BITS-1:0];
            r_value <= s_tdata[POS_BITS+DATA_BITS-1:POS_BITS];
        end
    end

    // Request FSM with the registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= w_out_load || (r_out_valid && !m_tready);
            unique case (r_state)
                S_IDLE: begin
                    if (s_tvalid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_req == REQ_SEARCH) begin
                        r_state <= S_SCAN;
                    end else if (w_out_free) begin
                        r_state  <= S_IDLE;
                        r_index  <= '0;
                        r_length <= LEN_BITS'(n_count);
                        r_data   <= w_exec_data;
                        r_status <= w_exec_status;
                    end
                end
                S_SCAN: begin
                    if (w_find_done && w_out_free) begin
                        r_state  <= S_IDLE;
                        r_data   <= '0;
                        r_length <= LEN_BITS'(r_count);
                        r_status <= w_find_found ? STAT_OK : STAT_MISS;
                        r_index  <= w_find_found ? INDEX_BITS'(w_find_index) : '0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_status;
    assign m_tdata  = {3'b000, r_length, r_index, r_data};

    // The length never exceeds the row.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("list length beyond depth");

    // A taken request goes straight to execution.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> (r_state == S_EXEC))
        else $error("accepted request not executed");

    // An insert grows the list by one, a remove shrinks it by one.
    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.ins |=> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("insert did not grow the list");

    a_rem_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.rem |=> (r_count == CW'($past(r_count) - 1'b1)))
        else $error("remove did not shrink the list");

    // The scanner only finishes while a search is in progress, with the row at rest.
    a_scan_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_find_done |-> ((r_state == S_SCAN) && !w_ctrl.ins && !w_ctrl.rem))
        else $error("scanner active outside a search");

endmodule

>>> tb/sv/indexed_sequence_list_core_tb.sv
// Self-checking stream testbench for the indexed sequence list core.
module indexed_sequence_list_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import islc_pkg::*;

    localparam int LIST_DEPTH  = 64;
    localparam int ITEM_TARGET = 1750;
    // Settle window after the last results have come back.
    localparam int SETTLE_CYCLES = 20;
    // Cycles without any transaction on either side before the run is called hung.
    localparam int STALL_LIMIT = 1000;

    // Operation mix used by one stretch of random traffic.
    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } t_mix;

    // Shadow copy of the list plus the queue of results it still owes.
    class list_scoreboard;
        typedef struct packed {
            t_status     status;
            logic [31:0] data;
            logic [5:0]  index;
            logic [6:0]  length;
        } t_list_result;

        logic [31:0]  words[$];
        t_list_result awaited[$];
        int           failures;
        int           checked;
        int           peak_len;
        int           req_seen[4];
        int           status_seen[4];

        function int length();
            return words.size();
        endfunction

        function logic [31:0] word_at(int i);
            return words[i];
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Apply one accepted request to the shadow list and queue its result.
        function void note_request(t_req req, logic [6:0] pos, logic [31:0] val);
            t_list_result r;
            int           i;
            r.status = STAT_OK;
            r.data   = '0;
            r.index  = '0;
            case (req)
                REQ_INSERT: begin
                    // Position is checked before capacity.
                    if (pos > words.size())
                        r.status = STAT_RANGE;
                    else if (words.size() >= LIST_DEPTH)
                        r.status = STAT_FULL;
                    else
                        words.insert(pos, val);
                end
                REQ_REMOVE: begin
                    if (pos >= words.size()) begin
                        r.status = STAT_RANGE;
                    end else begin
                        r.data = words[pos];
                        words.delete(pos);
                    end
                end
                REQ_SEARCH: begin
                    // First match wins; stop scanning once found.
                    r.status = STAT_MISS;
                    for (i = 0; i < words.size() && r.status == STAT_MISS; i++) begin
                        if (words[i] == val) begin
                            r.status = STAT_OK;
                            r.index  = 6'(i);
                        end
                    end
                end
                default: begin
                    if (pos >= words.size())
                        r.status = STAT_RANGE;
                    else
                        r.data = words[pos];
                end
            endcase
            r.length = 7'(words.size());
            if (words.size() > peak_len)
                peak_len = words.size();
            req_seen[req]++;
            status_seen[r.status]++;
            awaited.push_back(r);
        endfunction

        // Compare one result transaction against the oldest expectation.
        function void check_result(t_status st, logic [31:0] d, logic [5:0] ix,
                                   logic [6:0] ln);
            t_list_result e;
            if (awaited.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("[%0t] unexpected result: status %s data %h index %0d length %0d",
                             $realtime, st.name(), d, ix, ln);
                return;
            end
            e = awaited.pop_front();
            checked++;
            if (e.status !== st || e.data !== d || e.index !== ix || e.length !== ln) begin
                failures++;
                if (failures <= 10) begin
                    $display("[%0t] result mismatch:", $realtime);
                    $display("    expected status %s data %h index %0d length %0d",
                             e.status.name(), e.data, e.index, e.length);
                    $display("    actual   status %s data %h index %0d length %0d",
                             st.name(), d, ix, ln);
                end
            end
        endfunction
    endclass

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;    // [6:0] position, [38:7] value, [39] zero
    logic [1:0]  s_tuser  = '0;    // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;          // [31:0] data, [37:32] found_index, [44:38] length
    logic [1:0]  m_tuser;          // [1:0] status

    list_scoreboard sb = new();
    int             sent;
    int             idle_cycles;
    int             rx_cycle;

    indexed_sequence_list_core #(
        .DEPTH     (LIST_DEPTH),
        .WORD_BITS (32)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Receiver back-pressure: rotate through four patterns,
    // one of which never stalls, so stalls land on every phase of a request.
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        case (rx_cycle[9:8])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= 1'($urandom_range(1, 0));
            2'd2: m_tready <= ($urandom_range(3, 0) == 0);
            default: m_tready <= (rx_cycle[3:0] < 4'd11);
        endcase
    end

    // Check every result transaction as it is accepted.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_result(t_status'(m_tuser), m_tdata[31:0], m_tdata[37:32],
                            m_tdata[44:38]);
    end

    // Watchdog: end the run if nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, sb.pending());
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Present one request and hold it until the block takes it.
    task automatic send_request(input t_req req, input int pos, input logic [31:0] val);
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {1'b0, val, 7'(pos)};
        do @(posedge i_clk); while (!s_tready);
        sb.note_request(req, 7'(pos), val);
        sent++;
    endtask

    // Drop valid for a number of cycles.
    task automatic idle_sender(input int cycles);
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Corner cases on a small list: empty list, ends, middle, duplicates, range.
    task automatic run_directed();
        send_request(REQ_REMOVE, 0, 32'h0000_0000);   // remove from empty
        send_request(REQ_READ,   0, 32'h0000_0000);   // read from empty
        send_request(REQ_SEARCH, 0, 32'h0000_0000);   // search empty
        send_request(REQ_INSERT, 1, 32'h0000_0001);   // insert past end of empty
        send_request(REQ_INSERT, 0, 32'h7FFF_FFFF);
        send_request(REQ_INSERT, 1, 32'h8000_0000);   // append at back
        send_request(REQ_INSERT, 1, 32'hFFFF_FFFF);   // middle
        send_request(REQ_INSERT, 0, 32'h0000_0000);   // front
        send_request(REQ_READ,   3, 32'hFFFF_FFFF);
        send_request(REQ_READ,   4, 32'h0000_0000);   // read at length
        send_request(REQ_READ,   64, 32'h0000_0000);  // top position bit
        send_request(REQ_SEARCH, 0, 32'hFFFF_FFFF);
        send_request(REQ_SEARCH, 0, 32'h0000_3039);   // no match
        send_request(REQ_INSERT, 2, 32'h0000_0000);   // duplicate word
        send_request(REQ_SEARCH, 127, 32'h0000_0000); // first of two matches
        send_request(REQ_REMOVE, 4, 32'h0000_0000);   // back
        send_request(REQ_REMOVE, 0, 32'h0000_0000);   // front
        send_request(REQ_REMOVE, 1, 32'h0000_0000);   // middle
        send_request(REQ_REMOVE, 5, 32'h0000_0000);   // beyond length
        send_request(REQ_INSERT, 64, 32'h0000_0000);  // far past end
    endtask

    // Fill to capacity, then poke the full list at both ends.
    task automatic fill_and_probe();
        while (sb.length() < LIST_DEPTH)
            send_request(REQ_INSERT, $urandom_range(sb.length(), 0), $urandom);
        send_request(REQ_INSERT, 64, 32'h1234_5678);  // full, position at length
        send_request(REQ_INSERT, 0, 32'h1234_5678);   // full, front
        send_request(REQ_REMOVE, 64, 32'h0000_0000);  // out of range on full list
        send_request(REQ_READ,   63, 32'h0000_0000);  // last slot
        send_request(REQ_READ,   64, 32'h0000_0000);
        send_request(REQ_SEARCH, 0, sb.word_at(LIST_DEPTH - 1));
        send_request(REQ_REMOVE, 63, 32'h0000_0000);  // back of full list
    endtask

    // Build one random request, steered by the shadow list so most are legal.
    task automatic issue_random(input t_mix mix);
        t_req        req;
        int          pos;
        int          len;
        int          r;
        logic [31:0] val;
        len = sb.length();
        r   = $urandom_range(99, 0);
        case (mix)
            MIX_GROW:   req = (r < 55) ? REQ_INSERT : (r < 70) ? REQ_REMOVE :
                              (r < 85) ? REQ_SEARCH : REQ_READ;
            MIX_SHRINK: req = (r < 15) ? REQ_INSERT : (r < 70) ? REQ_REMOVE :
                              (r < 85) ? REQ_SEARCH : REQ_READ;
            default:    req = t_req'(r % 4);
        endcase

        // Position: mostly in range with weight on the ends, sometimes anything.
        if ($urandom_range(9, 0) < 2) begin
            pos = $urandom_range(64, 0);
        end else if (req == REQ_INSERT) begin
            case ($urandom_range(3, 0))
                0: pos = 0;
                1: pos = len;
                default: pos = $urandom_range(len, 0);
            endcase
        end else if (len == 0) begin
            pos = 0;
        end else begin
            case ($urandom_range(3, 0))
                0: pos = 0;
                1: pos = len - 1;
                default: pos = $urandom_range(len - 1, 0);
            endcase
        end

        // Word: half the searches aim at a stored entry; a small pool forces
        // duplicates so first-match ordering gets exercised.
        if (req == REQ_SEARCH && len > 0 && $urandom_range(1, 0)) begin
            val = sb.word_at($urandom_range(len - 1, 0));
        end else begin
            r = $urandom_range(9, 0);
            if (r < 4)
                val = $urandom;
            else if (r == 4)
                case ($urandom_range(3, 0))
                    0: val = 32'h0000_0000;
                    1: val = 32'hFFFF_FFFF;
                    2: val = 32'h7FFF_FFFF;
                    default: val = 32'h8000_0000;
                endcase
            else if (r < 8)
                val = $urandom_range(7, 0);
            else
                val = -$urandom_range(4, 1);
        end
        send_request(req, pos, val);
    endtask

    initial begin
        t_mix mix;
        int   stretch;
        int   burst;
        int   gap;
        int   k;

        // Hold reset, then release it on a falling edge.
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        fill_and_probe();
        drain_results();

        // Random traffic in stretches of one operation mix, sent in bursts.
        while (sent < ITEM_TARGET) begin
            mix     = t_mix'($urandom_range(2, 0));
            stretch = $urandom_range(200, 60);
            while (stretch > 0 && sent < ITEM_TARGET) begin
                burst = $urandom_range(16, 1);
                for (k = 0; k < burst && stretch > 0; k++) begin
                    issue_random(mix);
                    stretch--;
                end
                gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
                if (gap > 0)
                    idle_sender(gap);
            end
            if ($urandom_range(2, 0) == 0)
                drain_results();
        end

        // Let the last results come home, then allow a short settle window.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests: %0d insert, %0d remove, %0d search, %0d read;",
                 sent, sb.req_seen[REQ_INSERT], sb.req_seen[REQ_REMOVE],
                 sb.req_seen[REQ_SEARCH], sb.req_seen[REQ_READ]);
        $display("%0d checked; ok %0d, range %0d, full %0d, miss %0d; peak %0d, %0d errors.",
                 sb.checked, sb.status_seen[STAT_OK], sb.status_seen[STAT_RANGE],
                 sb.status_seen[STAT_FULL], sb.status_seen[STAT_MISS], sb.peak_len,
                 sb.failures);
        if (sb.pending() != 0)
            $display("%0d expected results never arrived", sb.pending());
        if (sb.failures == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
rtl/islc_pkg.sv
rtl/islc_cell.sv
rtl/islc_find.sv
rtl/indexed_sequence_list_core.sv
tb/sv/indexed_sequence_list_core_tb.sv
